// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file stl_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define STL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// Next-cycle implication, held off while reset is asserted.
`define STL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

// ===== rtl/core/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Types, token codes and character class helpers of the script token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int KEYWORD_MAX_LEN = 8;
    localparam int FLAG_TEXT_MAX   = 63;
    localparam int NUM_KW          = 24;
    localparam int NUM_SINGLE      = 14;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] LINE_TOP = 16'hFFFF;
    localparam logic [15:0] LEN_TOP  = 16'hFFFF;

    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_NUM     = 6'd1;
    localparam logic [5:0] K_IDENT   = 6'd2;
    localparam logic [5:0] K_SINGLE0 = 6'd3;
    localparam logic [5:0] K_MINUS   = 6'd13;
    localparam logic [5:0] K_SLASH   = 6'd15;
    localparam logic [5:0] K_KW0     = 6'd17;
    localparam logic [5:0] K_GLOBAL  = 6'd41;
    localparam logic [5:0] K_UNKNOWN = 6'd42;

    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_SLASH = 4'd1;
    localparam logic [3:0] M_LINEC = 4'd2;
    localparam logic [3:0] M_BLOCK = 4'd3;
    localparam logic [3:0] M_STAR  = 4'd4;
    localparam logic [3:0] M_MINUS = 4'd5;
    localparam logic [3:0] M_FLAG  = 4'd6;
    localparam logic [3:0] M_NUM   = 4'd7;
    localparam logic [3:0] M_EXP   = 4'd8;
    localparam logic [3:0] M_EXPD  = 4'd9;
    localparam logic [3:0] M_WORD  = 4'd10;

    // Words are held right aligned, first byte highest, so that a word of up
    // to eight bytes compares directly against a zero-extended string.
    localparam logic [63:0] GLOBAL_TEXT = 64'("global");

    localparam logic [63:0] KW_TABLE [NUM_KW] = '{
        64'("sprite"), 64'("stage"), 64'("when"), 64'("var"),
        64'("list"), 64'("forever"), 64'("repeat"), 64'("if"),
        64'("else"), 64'("not"), 64'("and"), 64'("or"),
        64'("mod"), 64'("to"), 64'("of"), 64'("by"),
        64'("for"), 64'("at"), 64'("with"), 64'("steps"),
        64'("degrees"), 64'("seconds"), 64'("secs"), 64'("contains")
    };

    localparam logic [7:0] SINGLE_TABLE [NUM_SINGLE] = '{
        8'h5B, 8'h5D, 8'h3C, 8'h3E, 8'h28, 8'h29, 8'h7B,
        8'h7D, 8'h25, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] length;
        logic [7:0]  fc;
    } token_t;

    typedef struct packed {
        logic [1:0]       cnt;
        token_t [2:0]     tok;
    } entry_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic [5:0] word_kind(input logic [63:0] w, input logic tl);
        logic [5:0] k;
        k = K_IDENT;
        if (!tl) begin
            for (int i = NUM_KW - 1; i >= 0; i--) begin
                if (w == KW_TABLE[i]) begin
                    k = K_KW0 + 6'(i);
                end
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/stl_channels.sv =====
// ----------------------------------------------------------------------------
// stl_channels
// Valid/ready channels for source bytes and for tokens.
// ----------------------------------------------------------------------------
interface stl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, in_byte, end_of_input, input ready);
    modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface stl_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] token_line;
    logic [15:0] token_length;
    logic [7:0]  first_char;
    logic        last_result;

    modport source (output valid, token_kind, token_line, token_length, first_char,
                    last_result, input ready);
    modport sink (input valid, token_kind, token_line, token_length, first_char,
                  last_result, output ready);
endinterface

// ===== rtl/core/stl_front.sv =====
// ----------------------------------------------------------------------------
// stl_front
// Scanner: takes one byte a cycle while the queue is not full and builds the tokens that byte completes.
// ----------------------------------------------------------------------------
module stl_front (
    input  logic             clk,
    input  logic             rst_n,
    stl_byte_if.sink         byte_in,
    input  logic             full,
    output logic             push,
    output stl_pkg::entry_t  push_data
);

    logic [3:0]  mode_reg, mode_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] sline_reg, sline_next;
    logic [15:0] run_reg, run_next;
    logic [63:0] word_reg, word_next;
    logic        tl_reg, tl_next;
    logic [7:0]  schar_reg, schar_next;

    logic            accept;
    logic [1:0]      n;
    stl_pkg::entry_t ent;

    assign byte_in.ready = !full;
    assign accept        = byte_in.valid && !full;
    assign push          = accept && (n != 2'd0);
    assign push_data     = ent;

    function automatic logic fin_valid(input logic [3:0] m);
        return m == stl_pkg::M_SLASH || m == stl_pkg::M_MINUS || m == stl_pkg::M_FLAG ||
               m == stl_pkg::M_NUM || m == stl_pkg::M_EXP || m == stl_pkg::M_EXPD ||
               m == stl_pkg::M_WORD;
    endfunction

    function automatic stl_pkg::token_t fin_tok(input logic [3:0] m, input logic [15:0] sl,
                                                input logic [15:0] run, input logic [63:0] w,
                                                input logic tl, input logic [7:0] sc);
        stl_pkg::token_t t;
        t = '{kind: stl_pkg::K_NUM, line: sl, length: run, fc: sc};
        unique case (m)
            stl_pkg::M_SLASH:
            begin
                t = '{kind: stl_pkg::K_SLASH, line: sl, length: 16'd1, fc: "/"};
            end
            stl_pkg::M_MINUS:
            begin
                t = '{kind: stl_pkg::K_MINUS, line: sl, length: 16'd1, fc: "-"};
            end
            stl_pkg::M_FLAG:
            begin
                if (run == 16'd6 && !tl && w == stl_pkg::GLOBAL_TEXT)
                begin
                    t = '{kind: stl_pkg::K_GLOBAL, line: sl, length: 16'd8, fc: "-"};
                end
                else
                begin
                    t = '{kind: stl_pkg::K_UNKNOWN, line: sl,
                          length: ((run < 16'(stl_pkg::FLAG_TEXT_MAX)) ? run :
                                   16'(stl_pkg::FLAG_TEXT_MAX)) + 16'd2,
                          fc: "-"};
                end
            end
            stl_pkg::M_WORD:
            begin
                t.kind = stl_pkg::word_kind(w, tl);
            end
            default:
            begin
                t.kind = stl_pkg::K_NUM;
            end
        endcase
        return t;
    endfunction

    always_comb
    begin
        logic [7:0]  b;
        logic        go_idle;
        logic        hit;
        logic [5:0]  sidx;
        b          = byte_in.in_byte;
        go_idle    = 1'b0;
        hit        = 1'b0;
        sidx       = '0;
        n          = 2'd0;
        ent        = '0;
        mode_next  = mode_reg;
        line_next  = line_reg;
        sline_next = sline_reg;
        run_next   = run_reg;
        word_next  = word_reg;
        tl_next    = tl_reg;
        schar_next = schar_reg;

        if (b != 8'd0)
        begin
            unique case (mode_reg)
                stl_pkg::M_SLASH:
                begin
                    if (b == "/") mode_next = stl_pkg::M_LINEC;
                    else if (b == "*") mode_next = stl_pkg::M_BLOCK;
                    else go_idle = 1'b1;
                end
                stl_pkg::M_LINEC:
                begin
                    if (b == 8'h0A) go_idle = 1'b1;
                end
                stl_pkg::M_BLOCK:
                begin
                    if (b == "*") mode_next = stl_pkg::M_STAR;
                    else if (b == 8'h0A && line_next != stl_pkg::LINE_TOP)
                        line_next = line_next + 16'd1;
                end
                stl_pkg::M_STAR:
                begin
                    if (b == "/") mode_next = stl_pkg::M_IDLE;
                    else if (b != "*")
                    begin
                        mode_next = stl_pkg::M_BLOCK;
                        if (b == 8'h0A && line_next != stl_pkg::LINE_TOP)
                            line_next = line_next + 16'd1;
                    end
                end
                stl_pkg::M_MINUS:
                begin
                    if (b == "-") mode_next = stl_pkg::M_FLAG;
                    else go_idle = 1'b1;
                end
                stl_pkg::M_FLAG, stl_pkg::M_WORD:
                begin
                    if ((mode_reg == stl_pkg::M_FLAG && !stl_pkg::is_space(b)) ||
                        (mode_reg == stl_pkg::M_WORD &&
                         (stl_pkg::is_alpha(b) || stl_pkg::is_digit(b) || b == "_" ||
                          b == "?" || b >= 8'h80)))
                    begin
                        if (run_next < 16'(stl_pkg::KEYWORD_MAX_LEN))
                            word_next = {word_next[55:0], b};
                        else
                            tl_next = 1'b1;
                        if (run_next != stl_pkg::LEN_TOP) run_next = run_next + 16'd1;
                    end
                    else go_idle = 1'b1;
                end
                stl_pkg::M_NUM:
                begin
                    if (stl_pkg::is_digit(b) || b == "." || b == "e" || b == "E")
                    begin
                        if (run_next != stl_pkg::LEN_TOP) run_next = run_next + 16'd1;
                        if (b == "e" || b == "E") mode_next = stl_pkg::M_EXP;
                    end
                    else go_idle = 1'b1;
                end
                stl_pkg::M_EXP:
                begin
                    if (stl_pkg::is_digit(b) || b == "+" || b == "-")
                    begin
                        if (run_next != stl_pkg::LEN_TOP) run_next = run_next + 16'd1;
                        mode_next = stl_pkg::M_EXPD;
                    end
                    else go_idle = 1'b1;
                end
                stl_pkg::M_EXPD:
                begin
                    if (stl_pkg::is_digit(b))
                    begin
                        if (run_next != stl_pkg::LEN_TOP) run_next = run_next + 16'd1;
                    end
                    else go_idle = 1'b1;
                end
                default:
                begin
                    go_idle = 1'b1;
                end
            endcase

            if (go_idle)
            begin
                // The pending token closes, then this byte starts over from idle.
                if (fin_valid(mode_reg))
                begin
                    ent.tok[n] = fin_tok(mode_reg, sline_next, run_next, word_next,
                                         tl_next, schar_next);
                    n = n + 2'd1;
                end
                mode_next = stl_pkg::M_IDLE;
                for (int i = 0; i < stl_pkg::NUM_SINGLE; i++)
                begin
                    if (!hit && b == stl_pkg::SINGLE_TABLE[i])
                    begin
                        hit  = 1'b1;
                        sidx = 6'(i);
                    end
                end
                if (stl_pkg::is_space(b))
                begin
                    if (b == 8'h0A && line_next != stl_pkg::LINE_TOP)
                        line_next = line_next + 16'd1;
                end
                else if (b == "/" || b == "-" || stl_pkg::is_digit(b) ||
                         stl_pkg::is_alpha(b) || b == "_" || b >= 8'h80)
                begin
                    sline_next = line_next;
                    schar_next = b;
                    run_next   = 16'd1;
                    word_next  = '0;
                    tl_next    = 1'b0;
                    if (b == "/")
                    begin
                        mode_next = stl_pkg::M_SLASH;
                        run_next  = 16'd0;
                    end
                    else if (b == "-")
                    begin
                        mode_next = stl_pkg::M_MINUS;
                        run_next  = 16'd0;
                    end
                    else if (stl_pkg::is_digit(b))
                        mode_next = stl_pkg::M_NUM;
                    else
                    begin
                        mode_next = stl_pkg::M_WORD;
                        word_next = {56'd0, b};
                    end
                end
                else if (hit)
                begin
                    ent.tok[n] = '{kind: stl_pkg::K_SINGLE0 + sidx, line: line_next,
                                   length: 16'd1, fc: b};
                    n = n + 2'd1;
                end
                else
                begin
                    ent.tok[n] = '{kind: stl_pkg::K_UNKNOWN, line: line_next,
                                   length: 16'd1, fc: b};
                    n = n + 2'd1;
                end
            end
        end

        if (b == 8'd0 || byte_in.end_of_input)
        begin
            if (fin_valid(mode_next))
            begin
                ent.tok[n] = fin_tok(mode_next, sline_next, run_next, word_next,
                                     tl_next, schar_next);
                n = n + 2'd1;
            end
            ent.tok[n] = '{kind: stl_pkg::K_EOF, line: line_next, length: 16'd0, fc: 8'd0};
            n = n + 2'd1;
            mode_next  = stl_pkg::M_IDLE;
            sline_next = line_next;
            run_next   = 16'd0;
            word_next  = '0;
            tl_next    = 1'b0;
            schar_next = 8'd0;
        end
        ent.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stl_pkg::M_IDLE;
            line_reg  <= 16'd1;
            sline_reg <= 16'd1;
            run_reg   <= 16'd0;
            word_reg  <= '0;
            tl_reg    <= 1'b0;
            schar_reg <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            sline_reg <= sline_next;
            run_reg   <= run_next;
            word_reg  <= word_next;
            tl_reg    <= tl_next;
            schar_reg <= schar_next;
        end
    end

endmodule

// ===== rtl/core/stl_queue.sv =====
// ----------------------------------------------------------------------------
// stl_queue
// Short queue of token groups between the scanner and the output stage.
// ----------------------------------------------------------------------------
module stl_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  stl_pkg::entry_t  push_data,
    output logic             full,
    input  logic             pop,
    output stl_pkg::entry_t  pop_data,
    output logic             empty
);

    stl_pkg::entry_t             mem_reg [stl_pkg::QUEUE_DEPTH];
    logic [stl_pkg::QPTR_W-1:0]  wr_reg, rd_reg;
    logic [stl_pkg::QPTR_W:0]    cnt_reg;

    assign full     = cnt_reg == (stl_pkg::QPTR_W + 1)'(stl_pkg::QUEUE_DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/core/stl_back.sv =====
// ----------------------------------------------------------------------------
// stl_back
// Output stage: hands out the tokens of each group one word at a time.
// ----------------------------------------------------------------------------
module stl_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  stl_pkg::entry_t  head,
    output logic             pop,
    stl_token_if.source      token_out
);

    stl_pkg::entry_t ent_reg;
    logic [1:0]      idx_reg;
    logic            busy_reg;
    logic            last;
    logic            done;
    stl_pkg::token_t cur;

    assign cur  = ent_reg.tok[idx_reg];
    assign last = idx_reg == (ent_reg.cnt - 2'd1);
    assign done = busy_reg && token_out.ready && last;
    assign pop  = !empty && (!busy_reg || done);

    assign token_out.valid        = busy_reg;
    assign token_out.token_kind   = cur.kind;
    assign token_out.token_line   = cur.line;
    assign token_out.token_length = cur.length;
    assign token_out.first_char   = cur.fc;
    assign token_out.last_result  = last;

    always_ff @(posedge clk)
    begin
        if (pop) ent_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && token_out.ready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// ===== rtl/core/script_token_lexer_top.sv =====
// A token is held in the token queue and then in the output stage register.
// Throughput: one byte per cycle while the queue has room; the output gives
// one token per cycle while the sink is ready, so bytes that close several
// tokens at once fill the four-group queue and stall input.
// Reset (rst_n low, asynchronous): scanner idle, line count one, queue and
// output stage empty.
// ----------------------------------------------------------------------------
// script_token_lexer_top
// Byte-stream lexer: scanner, token queue and output stage.
// ----------------------------------------------------------------------------
module script_token_lexer_top (
    input  logic         clk,
    input  logic         rst_n,
    stl_byte_if.sink     byte_in,
    stl_token_if.source  token_out
);

    logic            push, pop, full, empty;
    stl_pkg::entry_t push_data, head;

    stl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    stl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty)
    );

    stl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .token_out (token_out)
    );

endmodule

// ===== rtl/core/stl_checker.sv =====
// ----------------------------------------------------------------------------
// stl_checker
// Port-level checks on the token output of the lexer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  token_kind,
    input logic [15:0] token_line,
    input logic [15:0] token_length,
    input logic [7:0]  first_char,
    input logic        last_result
);

    `STL_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_line))
    `STL_ASSERT_IMP(a_eof_last, clk, rst_n, out_valid && token_kind == stl_pkg::K_EOF, last_result)
    `STL_ASSERT_IMP(a_eof_empty, clk, rst_n, out_valid && token_kind == stl_pkg::K_EOF, token_length == 16'd0 && first_char == 8'd0)
    `STL_ASSERT_IMP(a_line_nz, clk, rst_n, out_valid, token_line != 16'd0)

endmodule

bind script_token_lexer_top stl_checker u_stl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (token_out.valid),
    .out_ready    (token_out.ready),
    .token_kind   (token_out.token_kind),
    .token_line   (token_out.token_line),
    .token_length (token_out.token_length),
    .first_char   (token_out.first_char),
    .last_result  (token_out.last_result)
);

// ===== bench/tb_stl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stl_checker
// Watches the byte and token channels of the lexer, predicts the tokens that
// every accepted byte word causes and compares them with the tokens that come
// out, field by field and in order.
// ----------------------------------------------------------------------------
module tb_stl_checker
    import stl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    input  logic        tok_valid,
    input  logic        tok_ready,
    input  logic [5:0]  token_kind,
    input  logic [15:0] token_line,
    input  logic [15:0] token_length,
    input  logic [7:0]  first_char,
    input  logic        last_result,
    output int          fail_count,
    output int          tokens_pending,
    output int          tokens_seen
);

    typedef struct {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] length;
        logic [7:0]  fc;
        logic        last;
    } token_exp_t;

    localparam int unsigned SAT16 = 65535;

    string singles = "[]<>(){}%+-*/=";
    string kw_names [NUM_KW] = '{
        "sprite", "stage", "when", "var", "list", "forever", "repeat", "if",
        "else", "not", "and", "or", "mod", "to", "of", "by", "for", "at",
        "with", "steps", "degrees", "seconds", "secs", "contains"
    };

    token_exp_t  expected_tokens [$];
    token_exp_t  step_tokens [$];

    logic [3:0]  scan_mode;
    int unsigned line_no;
    int unsigned tok_line;
    int unsigned run_len;
    logic [63:0] word_text;
    logic        word_long;
    logic [7:0]  tok_char;

    assign tokens_pending = expected_tokens.size();

    function automatic bit blank(input logic [7:0] b);
        return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic bit numeral(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic bit letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    // Packs text with its first byte lowest, the same way word_text is built.
    function automatic logic [63:0] pack_word(input string s);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
            v[8*i +: 8] = s[i];
        return v;
    endfunction

    task automatic add_token(input logic [5:0] kind, input int unsigned line,
                             input int unsigned len, input logic [7:0] fc);
        token_exp_t t;
        t.kind = kind;
        t.line = line[15:0];
        t.length = len[15:0];
        t.fc = fc;
        t.last = 1'b0;
        if (step_tokens.size() < 3)
            step_tokens.push_back(t);
    endtask

    task automatic grow_run();
        if (run_len < SAT16)
            run_len++;
    endtask

    task automatic take_char(input logic [7:0] b);
        if (run_len < KEYWORD_MAX_LEN)
            word_text[8*run_len +: 8] = b;
        else
            word_long = 1'b1;
        grow_run();
    endtask

    task automatic open_token(input logic [3:0] mode, input logic [7:0] b);
        scan_mode = mode;
        tok_line = line_no;
        tok_char = b;
        run_len = 0;
        word_text = '0;
        word_long = 1'b0;
    endtask

    task automatic count_line();
        if (line_no < SAT16)
            line_no++;
    endtask

    task automatic close_token();
        logic [5:0]  kind;
        int unsigned len;
        case (scan_mode)
            M_SLASH: add_token(K_SLASH, tok_line, 1, "/");
            M_MINUS: add_token(K_MINUS, tok_line, 1, "-");
            M_FLAG:
            begin
                if (run_len == 6 && !word_long && word_text == pack_word("global"))
                    add_token(K_GLOBAL, tok_line, 8, "-");
                else
                begin
                    len = (run_len < FLAG_TEXT_MAX) ? run_len : FLAG_TEXT_MAX;
                    add_token(K_UNKNOWN, tok_line, len + 2, "-");
                end
            end
            M_NUM, M_EXP, M_EXPD: add_token(K_NUM, tok_line, run_len, tok_char);
            M_WORD:
            begin
                kind = K_IDENT;
                if (!word_long)
                begin
                    for (int i = NUM_KW - 1; i >= 0; i--)
                        if (word_text == pack_word(kw_names[i]))
                            kind = K_KW0 + 6'(i);
                end
                add_token(kind, tok_line, run_len, tok_char);
            end
            default: ;
        endcase
        scan_mode = M_IDLE;
    endtask

    task automatic start_from_idle(input logic [7:0] b);
        if (blank(b))
        begin
            if (b == 8'h0A)
                count_line();
        end
        else if (b == "/")
            open_token(M_SLASH, b);
        else if (b == "-")
            open_token(M_MINUS, b);
        else
        begin
            for (int i = 0; i < NUM_SINGLE; i++)
            begin
                if (singles[i] == b)
                begin
                    add_token(K_SINGLE0 + 6'(i), line_no, 1, b);
                    return;
                end
            end
            if (numeral(b))
            begin
                open_token(M_NUM, b);
                grow_run();
            end
            else if (letter(b) || b == "_" || b >= 8'h80)
            begin
                open_token(M_WORD, b);
                take_char(b);
            end
            else
                add_token(K_UNKNOWN, line_no, 1, b);
        end
    endtask

    task automatic scan_byte(input logic [7:0] b);
        bit again;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (scan_mode)
                M_SLASH:
                    if (b == "/") scan_mode = M_LINEC;
                    else if (b == "*") scan_mode = M_BLOCK;
                    else begin close_token(); again = 1'b1; end
                M_LINEC:
                    if (b == 8'h0A) begin scan_mode = M_IDLE; again = 1'b1; end
                M_BLOCK:
                    if (b == "*") scan_mode = M_STAR;
                    else if (b == 8'h0A) count_line();
                M_STAR:
                    if (b == "/") scan_mode = M_IDLE;
                    else if (b != "*")
                    begin
                        scan_mode = M_BLOCK;
                        if (b == 8'h0A) count_line();
                    end
                M_MINUS:
                    if (b == "-") scan_mode = M_FLAG;
                    else begin close_token(); again = 1'b1; end
                M_FLAG:
                    if (blank(b)) begin close_token(); again = 1'b1; end
                    else take_char(b);
                M_NUM:
                    if (numeral(b) || b == ".") grow_run();
                    else if (b == "e" || b == "E") begin grow_run(); scan_mode = M_EXP; end
                    else begin close_token(); again = 1'b1; end
                M_EXP:
                    if (numeral(b) || b == "+" || b == "-")
                    begin
                        grow_run();
                        scan_mode = M_EXPD;
                    end
                    else begin close_token(); again = 1'b1; end
                M_EXPD:
                    if (numeral(b)) grow_run();
                    else begin close_token(); again = 1'b1; end
                M_WORD:
                    if (letter(b) || numeral(b) || b == "_" || b == "?" || b >= 8'h80)
                        take_char(b);
                    else begin close_token(); again = 1'b1; end
                default:
                begin
                    scan_mode = M_IDLE;
                    start_from_idle(b);
                end
            endcase
        end
    endtask

    task automatic predict_tokens(input logic [7:0] b, input logic eoi);
        step_tokens.delete();
        if (b != 8'd0)
            scan_byte(b);
        if (b == 8'd0 || eoi)
        begin
            close_token();
            add_token(K_EOF, line_no, 0, 8'd0);
            open_token(M_IDLE, 8'd0);
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endtask

    task automatic report(input string what, input logic [15:0] got,
                          input logic [15:0] want);
        $display("%0t token mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        tokens_seen = 0;
        scan_mode = M_IDLE;
        line_no = 1;
        open_token(M_IDLE, 8'd0);
    end

    always @(posedge clk)
    begin
        token_exp_t e;
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
                predict_tokens(in_byte, end_of_input);
            if (tok_valid && tok_ready)
            begin
                tokens_seen++;
                if (expected_tokens.size() == 0)
                begin
                    // Nothing was expected, so any kind is a mismatch.
                    report("kind of an unexpected token", 16'(token_kind), 16'd0);
                end
                else
                begin
                    e = expected_tokens.pop_front();
                    if (token_kind !== e.kind) report("kind", 16'(token_kind), 16'(e.kind));
                    if (token_line !== e.line) report("line", token_line, e.line);
                    if (token_length !== e.length) report("length", token_length, e.length);
                    if (first_char !== e.fc) report("first_char", 16'(first_char), 16'(e.fc));
                    if (last_result !== e.last) report("last", 16'(last_result), 16'(e.last));
                end
            end
        end
    end

endmodule

// ===== bench/tb_script_token_lexer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_script_token_lexer_top
// Feeds the lexer a directed source text and then random fragments of script
// text and noise, with random gaps on both channels; the checker beside the
// block predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_script_token_lexer_top;
    import stl_pkg::*;

    logic clk;
    logic rst_n;
    int   bytes_sent;
    int   fail_count;
    int   tokens_pending;
    int   tokens_seen;
    bit   calm;

    stl_byte_if  byte_ch ();
    stl_token_if token_ch ();

    script_token_lexer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_ch),
        .token_out (token_ch)
    );

    tb_stl_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_ch.valid),
        .byte_ready     (byte_ch.ready),
        .in_byte        (byte_ch.in_byte),
        .end_of_input   (byte_ch.end_of_input),
        .tok_valid      (token_ch.valid),
        .tok_ready      (token_ch.ready),
        .token_kind     (token_ch.token_kind),
        .token_line     (token_ch.token_line),
        .token_length   (token_ch.token_length),
        .first_char     (token_ch.first_char),
        .last_result    (token_ch.last_result),
        .fail_count     (fail_count),
        .tokens_pending (tokens_pending),
        .tokens_seen    (tokens_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("tb_script_token_lexer_top NOT OK");
        $finish;
    end

    // Sends one word; valid stays high across back-to-back words.
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.in_byte <= b;
        byte_ch.end_of_input <= eoi;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_byte(s[i], ($urandom_range(0, 59) == 0));
    endtask

    function automatic string rand_word(input int n, input bit tail_mix);
        string s;
        int r;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, tail_mix && i > 0 ? 4 : 2);
            case (r)
                0: s = {s, string'(8'($urandom_range(8'h61, 8'h7A)))};
                1: s = {s, string'(8'($urandom_range(8'h41, 8'h5A)))};
                2: s = {s, (i == 0) ? "_" : string'(8'($urandom_range(8'h80, 8'hFF)))};
                3: s = {s, string'(8'($urandom_range(8'h30, 8'h39)))};
                default: s = {s, "?"};
            endcase
        end
        return s;
    endfunction

    function automatic string rand_fragment();
        string kws [NUM_KW] = '{
            "sprite", "stage", "when", "var", "list", "forever", "repeat", "if",
            "else", "not", "and", "or", "mod", "to", "of", "by", "for", "at",
            "with", "steps", "degrees", "seconds", "secs", "contains"
        };
        string seps [4] = '{" ", "\n", "\t", "  \n"};
        string s;
        case ($urandom_range(0, 11))
            0, 1: s = kws[$urandom_range(0, NUM_KW - 1)];
            2: s = rand_word($urandom_range(1, 12), 1'b1);
            3: s = $sformatf("%0d.%0d%s", $urandom_range(0, 999), $urandom_range(0, 99),
                             ($urandom_range(0, 1) ? "e-7" : "E"));
            4: s = $sformatf("%0d", $urandom_range(0, 99999));
            5: s = "[]<>(){}%+*=";
            6: s = {"// ", rand_word(3, 1'b0), "\n"};
            7: s = {"/* ", rand_word(2, 1'b0), "\n**x*/"};
            8: s = ($urandom_range(0, 2) == 0) ? "--global" :
                   {"--", rand_word($urandom_range(1, 8), 1'b1)};
            9: s = {($urandom_range(0, 1) ? "/" : "-"), rand_word(1, 1'b0)};
            10: s = string'(8'($urandom_range(1, 255)));
            default: s = seps[$urandom_range(0, 3)];
        endcase
        return {s, seps[$urandom_range(0, 3)]};
    endfunction

    // Token sink: random stall before each word, with calm stretches.
    initial
    begin
        int gap;
        token_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = calm ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                token_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            token_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(token_ch.valid && token_ch.ready))
                @(posedge clk);
        end
    end

    initial
    begin
        int n;
        string flag_long;
        string directed;
        bytes_sent = 0;
        calm = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.in_byte = 8'd0;
        byte_ch.end_of_input = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a flag, lone slash and minus, short exponents, both comment
        // kinds, a high byte, a zero byte and end markers on bytes.
        directed = "--global -/x_9 1e+ 3.E5/*\n*/ //\n@\x80?";
        foreach (directed[i])
            send_byte(directed[i], 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte("/", 1'b1);
        send_byte("7", 1'b1);
        send_byte("-", 1'b1);

        flag_long = "--";
        for (int i = 0; i < 70; i++)
            flag_long = {flag_long, "q"};
        n = 0;
        while (bytes_sent < 210)
        begin
            n++;
            if (n % 15 == 0)
                calm = ~calm;
            if (n == 20)
                send_text({flag_long, " abcdefghij\n"});
            else if ($urandom_range(0, 9) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                send_text(rand_fragment());
        end
        send_byte(8'd0, 1'b1);
        byte_ch.valid <= 1'b0;

        while (tokens_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d source bytes of keywords, words, numbers, flags, comments", bytes_sent);
        $display("and noise; checked %0d tokens.", tokens_seen);
        if (fail_count == 0)
            $display("tb_script_token_lexer_top OK");
        else
            $display("tb_script_token_lexer_top NOT OK");
        $finish;
    end

endmodule
